// ===== rtl/bsl_pkg.sv =====
`default_nettype none

package bsl_pkg;

    // list geometry
    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    // widths fixed by the port fields
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // internal widths
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CMP_W-1:0]     t_idx;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD_BACK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    // cell operations
    localparam logic [1:0] OP_HOLD     = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_SHIFT_DN = 2'd2;

    // control broadcast to every cell
    typedef struct packed {
        logic [1:0] op;
        t_idx       pos;
        t_word      word;
        t_idx       sel;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/bounded_shift_list_unit.sv =====
`default_nettype none

// channel | valid       | stall       | payload
// in      | i_in_valid  | o_in_stall  | i_command, i_item_value, i_position
// out     | o_out_valid | i_out_stall | o_status, o_read_value, o_count,
//         |             |             | o_front_value, o_back_value
//
// the block takes no new item until the result of the last one has been taken:
// the cell row shifts at the accepting edge, a busy state then picks the new back
// element off the read bus, the result is offered until taken, then the next item is taken.
// synchronous active-low reset clears the length and the handshake state.
// input stays stalled while an item is in work or its result is waiting.
module bounded_shift_list_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [bsl_pkg::CMD_W-1:0]        i_command,
    input  wire  signed [bsl_pkg::DATA_W-1:0] i_item_value,
    input  wire  [bsl_pkg::POS_W-1:0]        i_position,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [bsl_pkg::STATUS_W-1:0]     o_status,
    output logic signed [bsl_pkg::DATA_W-1:0] o_read_value,
    output logic [bsl_pkg::COUNT_W-1:0]      o_count,
    output logic signed [bsl_pkg::DATA_W-1:0] o_front_value,
    output logic signed [bsl_pkg::DATA_W-1:0] o_back_value
);
    import bsl_pkg::*;

    t_cnt  r_len;
    t_cnt  n_len;
    logic  r_busy;
    logic  r_out_valid;
    logic  [STATUS_W-1:0] r_status;
    logic  [STATUS_W-1:0] n_status;
    t_word r_read;
    t_word n_read;
    t_word r_front;
    t_word r_back;

    t_cell_ctrl w_ctrl;
    t_word      w_word [CAPACITY];
    t_word      w_tap  [CAPACITY];
    t_word      w_bus;

    logic  w_accept;
    logic  w_full;
    logic  w_empty;
    t_idx  w_pos;
    t_idx  w_len;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_full   = (r_len == t_cnt'(CAPACITY));
    assign w_empty  = (r_len == '0);
    assign w_pos    = t_idx'(i_position);
    assign w_len    = t_idx'(r_len);

    // command decode
    always_comb begin
        w_ctrl.op   = OP_HOLD;
        w_ctrl.pos  = w_pos;
        w_ctrl.word = t_word'(i_item_value);
        w_ctrl.sel  = r_busy ? (w_len - t_idx'(1)) : w_pos;
        n_len       = r_len;
        n_status    = ST_OK;
        if (w_accept) begin
            unique case (i_command)
                CMD_ADD_BACK, CMD_ADD_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.op  = OP_INSERT;
                        w_ctrl.pos = (i_command == CMD_ADD_BACK) ? w_len : '0;
                        n_len      = r_len + t_cnt'(1);
                    end
                end
                CMD_DROP_BACK, CMD_DROP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        if (i_command == CMD_DROP_FRONT) begin
                            w_ctrl.op = OP_SHIFT_DN;
                        end
                        n_len = r_len - t_cnt'(1);
                    end
                end
                CMD_INSERT: begin
                    if (w_pos > w_len) begin
                        n_status = ST_BADIDX;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.op = OP_INSERT;
                        n_len     = r_len + t_cnt'(1);
                    end
                end
                CMD_READ: begin
                    if (w_pos >= w_len) begin
                        n_status = ST_BADIDX;
                    end
                end
                CMD_CLEAR: begin
                    n_len = '0;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    // word picked off the read bus for an in-range read
    assign n_read = (w_accept && (i_command == CMD_READ) && (w_pos < w_len)) ? w_bus : '0;

    // row of cells, each handing its word to a neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_lower;
        t_word w_upper;
        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_word[g+1];
        end
        bsl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (t_idx'(g)),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_word  (w_word[g]),
            .o_tap   (w_tap[g])
        );
    end

    // and-or read bus over the cell taps
    always_comb begin
        w_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_bus = w_bus | w_tap[k];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_read   <= n_read;
        end
        if (r_busy) begin
            r_front <= w_empty ? '0 : w_word[0];
            r_back  <= w_empty ? '0 : w_bus;
        end
    end

    assign o_in_stall    = r_busy || r_out_valid;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = DATA_W'(r_read);
    assign o_count       = COUNT_W'(r_len);
    assign o_front_value = DATA_W'(r_front);
    assign o_back_value  = DATA_W'(r_back);

endmodule

`default_nettype wire

// ===== rtl/bsl_cell.sv =====
`default_nettype none

module bsl_cell (
    input  wire                 i_clk,
    input  bsl_pkg::t_cell_ctrl i_ctrl,
    input  bsl_pkg::t_idx       i_index,
    input  bsl_pkg::t_word      i_lower,
    input  bsl_pkg::t_word      i_upper,
    output bsl_pkg::t_word      o_word,
    output bsl_pkg::t_word      o_tap
);
    import bsl_pkg::*;

    t_word r_word;
    t_word n_word;

    // next word: hold, take new word, take neighbor below or above
    always_comb begin
        n_word = r_word;
        unique case (i_ctrl.op)
            OP_INSERT: begin
                if (i_index == i_ctrl.pos) begin
                    n_word = i_ctrl.word;
                end else if (i_index > i_ctrl.pos) begin
                    n_word = i_lower;
                end
            end
            OP_SHIFT_DN: begin
                n_word = i_upper;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // drive the shared and-or read bus when selected
    assign o_word = r_word;
    assign o_tap  = (i_index == i_ctrl.sel) ? r_word : '0;

endmodule

`default_nettype wire

// ===== verif/bounded_shift_list_unit_test.sv =====
`default_nettype none

module bounded_shift_list_unit_test;

    import bsl_pkg::*;

    // code outside the defined command set, answered with ST_OK and no change to the list
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_PCT     = 25;
    localparam int CALM_FIRST   = 350;
    localparam int CALM_LAST    = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int STUCK_LIMIT  = 2000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
    } t_list_cmd;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } t_list_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command = '0;
    logic signed [DATA_W-1:0] i_item_value = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_read_value;
    logic [COUNT_W-1:0]       o_count;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_back_value;

    t_list_cmd    pending_cmds[$];
    t_list_result expected_results[$];
    t_list_cmd    presented_cmd;

    // shadow copy of the list contents
    t_word list_slots[CAPACITY];
    int    list_len;

    int cmds_taken;
    int results_taken;
    int mismatches;
    int stuck_cycles;

    bounded_shift_list_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_item_value  (i_item_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // update the shadow list with one command and return what the block should answer
    function automatic t_list_result apply_list_cmd(t_list_cmd c);
        t_list_result r;
        int i;
        r.status     = ST_OK;
        r.read_value = '0;
        case (c.cmd)
            CMD_ADD_BACK: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_slots[list_len] = c.value;
                    list_len++;
                end
            end
            CMD_ADD_FRONT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > 0; i--) list_slots[i] = list_slots[i-1];
                    list_slots[0] = c.value;
                    list_len++;
                end
            end
            CMD_DROP_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            CMD_DROP_FRONT: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = 1; i < list_len; i++) list_slots[i-1] = list_slots[i];
                    list_len--;
                end
            end
            CMD_INSERT: begin
                // the index check wins over the full check
                if (int'(c.pos) > list_len) begin
                    r.status = ST_BADIDX;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > int'(c.pos); i--) list_slots[i] = list_slots[i-1];
                    list_slots[c.pos] = c.value;
                    list_len++;
                end
            end
            CMD_READ: begin
                if (int'(c.pos) >= list_len) r.status = ST_BADIDX;
                else r.read_value = list_slots[c.pos];
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.count       = COUNT_W'(list_len);
        r.front_value = (list_len > 0) ? list_slots[0] : '0;
        r.back_value  = (list_len > 0) ? list_slots[list_len-1] : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("mismatch on result %0d: %s got %0h, want %0h",
                 results_taken, what, got, want);
        mismatches++;
    endtask

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                             logic [POS_W-1:0] pos);
        t_list_cmd c;
        c.cmd   = cmd;
        c.value = value;
        c.pos   = pos;
        pending_cmds = {pending_cmds, c};
    endtask

    // driver: presents queued items, idles at random outside the calm stretch
    always @(posedge i_clk) begin
        t_list_result exp_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                exp_item = apply_list_cmd(presented_cmd);
                expected_results = {expected_results, exp_item};
                cmds_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cmds.size() > 0 &&
                    ((cmds_taken >= CALM_FIRST && cmds_taken < CALM_LAST) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    presented_cmd = pending_cmds[0];
                    pending_cmds.delete(0);
                    i_command    <= presented_cmd.cmd;
                    i_item_value <= presented_cmd.value;
                    i_position   <= presented_cmd.pos;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stalls the output at random and checks each result item
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item status", DATA_W'(o_status), '0);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (o_status !== want.status)
                        report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                    if (o_read_value !== want.read_value)
                        report_mismatch("read_value", o_read_value, want.read_value);
                    if (o_count !== want.count)
                        report_mismatch("count", DATA_W'(o_count), DATA_W'(want.count));
                    if (o_front_value !== want.front_value)
                        report_mismatch("front_value", o_front_value, want.front_value);
                    if (o_back_value !== want.back_value)
                        report_mismatch("back_value", o_back_value, want.back_value);
                end
                results_taken++;
            end
            if (results_taken >= CALM_FIRST && results_taken < CALM_LAST)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        int n;
        int mode;
        int gen_len;
        int push_share;
        int pop_share;
        int roll;
        int total_cmds;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  pos;

        for (n = 0; n < CAPACITY; n++) list_slots[n] = '0;
        list_len      = 0;
        cmds_taken    = 0;
        results_taken = 0;
        mismatches    = 0;
        stuck_cycles  = 0;

        // empty list corner cases
        queue_cmd(CMD_READ, 32'h0, 5'd0);
        queue_cmd(CMD_DROP_BACK, 32'h0, 5'd0);
        queue_cmd(CMD_DROP_FRONT, 32'h0, 5'd0);
        queue_cmd(CMD_INSERT, 32'h1234_5678, 5'd1);
        queue_cmd(CMD_UNUSED, 32'hffff_ffff, 5'd31);
        // extremes of the word, every way in
        queue_cmd(CMD_INSERT, 32'h7fff_ffff, 5'd0);
        queue_cmd(CMD_ADD_FRONT, 32'h8000_0000, 5'd0);
        queue_cmd(CMD_ADD_BACK, 32'hffff_ffff, 5'd0);
        queue_cmd(CMD_INSERT, 32'h0, 5'd1);
        // fill to capacity
        for (n = 4; n < CAPACITY; n++) queue_cmd(CMD_ADD_BACK, $urandom, 5'd0);
        // full list corner cases
        queue_cmd(CMD_ADD_BACK, 32'h5555_5555, 5'd0);
        queue_cmd(CMD_INSERT, 32'haaaa_aaaa, 5'd16);
        queue_cmd(CMD_INSERT, 32'haaaa_aaaa, 5'd17);
        queue_cmd(CMD_READ, 32'h0, 5'd15);
        queue_cmd(CMD_READ, 32'h0, 5'd16);
        queue_cmd(CMD_DROP_FRONT, 32'h0, 5'd0);
        queue_cmd(CMD_CLEAR, 32'h0, 5'd0);

        // random part: phases that grow, shrink or churn the list
        mode    = 0;
        gen_len = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       begin push_share = 65; pop_share = 12; end
                1:       begin push_share = 15; pop_share = 60; end
                default: begin push_share = 40; pop_share = 30; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                cmd = CMD_CLEAR;
            end else if (roll < 4) begin
                cmd = CMD_UNUSED;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < push_share) begin
                    case ($urandom_range(0, 2))
                        0:       cmd = CMD_ADD_BACK;
                        1:       cmd = CMD_ADD_FRONT;
                        default: cmd = CMD_INSERT;
                    endcase
                end else if (roll < push_share + pop_share) begin
                    cmd = $urandom_range(0, 1) ? CMD_DROP_BACK : CMD_DROP_FRONT;
                end else begin
                    cmd = CMD_READ;
                end
            end

            // mostly in-range positions, some anywhere in the field
            if ($urandom_range(0, 99) < 85 && cmd == CMD_INSERT)
                pos = POS_W'($urandom_range(0, gen_len));
            else if ($urandom_range(0, 99) < 85 && cmd == CMD_READ && gen_len > 0)
                pos = POS_W'($urandom_range(0, gen_len - 1));
            else
                pos = POS_W'($urandom_range(0, 31));

            case ($urandom_range(0, 39))
                0:       value = 32'h7fff_ffff;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0;
                3:       value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            queue_cmd(cmd, value, pos);

            // track the length so positions stay mostly meaningful
            case (cmd)
                CMD_ADD_BACK, CMD_ADD_FRONT: if (gen_len < CAPACITY) gen_len++;
                CMD_INSERT: if (int'(pos) <= gen_len && gen_len < CAPACITY) gen_len++;
                CMD_DROP_BACK, CMD_DROP_FRONT: if (gen_len > 0) gen_len--;
                CMD_CLEAR: gen_len = 0;
                default: begin
                end
            endcase
        end
        total_cmds = pending_cmds.size();

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain until every queued item has come back
        @(posedge i_clk);
        while (results_taken < total_cmds)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0 &&
            results_taken == total_cmds) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
